>>> sv/jsi_pkg.sv
// jsi_pkg: codes, field widths and reset values for the joint slew interpolator.
// No dependencies; imported by joint_slew_interpolator_unit.
package jsi_pkg;

	localparam int OP_W    = 3;
	localparam int LEG_W   = 3;
	localparam int JOINT_W = 2;
	localparam int VAL_W   = 16;
	localparam int MT_W    = 16;
	localparam int LIM_W   = 15;
	localparam int TP_W    = 8;
	localparam int JOINTS  = 3;

	localparam logic [OP_W-1:0] OP_SET_CUR_ABS = 3'd0;
	localparam logic [OP_W-1:0] OP_SET_CUR_REL = 3'd1;
	localparam logic [OP_W-1:0] OP_SET_TGT_ABS = 3'd2;
	localparam logic [OP_W-1:0] OP_SET_TGT_REL = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK        = 3'd4;

	localparam logic [JOINT_W-1:0] JOINT_COXA  = 2'd0;
	localparam logic [JOINT_W-1:0] JOINT_FEMUR = 2'd1;
	localparam logic [JOINT_W-1:0] JOINT_TIBIA = 2'd2;

	localparam logic [1:0] REG_MAX_ANGLE   = 2'd0;
	localparam logic [1:0] REG_MIN_STEP    = 2'd1;
	localparam logic [1:0] REG_TICK_PERIOD = 2'd2;

	localparam logic [LIM_W-1:0] MAX_ANGLE_RESET   = 15'd23040;
	localparam logic [LIM_W-1:0] MIN_STEP_RESET    = 15'd64;
	localparam logic [TP_W-1:0]  TICK_PERIOD_RESET = 8'd20;

endpackage

>>> sv/joint_slew_interpolator_unit.sv
// joint_slew_interpolator_unit: per-joint slew limiter with APB register port.
// Depends on jsi_pkg (codes, widths, reset values).
// An item is taken only while idle; the next waits until the last is done. Set
// current sends one word per joint, a tick reads/compares then writes each joint
// of every leg, and set target is bounded by the shared shift-subtract divider
// (ANGLE_BITS+8 steps per joint). Ignored items leave the unit idle; output stalls
// hold set current and ticks. Reset (arst_n low) zeroes angles, loads step sizes
// and registers with their defaults; no clearing pass is needed.
module joint_slew_interpolator_unit #(
	parameter int LEGS       = 6,
	parameter int ANGLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [3:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [jsi_pkg::OP_W-1:0]     operation,
	input  logic [jsi_pkg::LEG_W-1:0]    leg_index,
	input  logic signed [jsi_pkg::VAL_W-1:0] coxa_value,
	input  logic signed [jsi_pkg::VAL_W-1:0] tibia_value,
	input  logic [jsi_pkg::MT_W-1:0]     move_time,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [jsi_pkg::LEG_W-1:0]    out_leg,
	output logic [jsi_pkg::JOINT_W-1:0]  out_joint,
	output logic signed [jsi_pkg::VAL_W-1:0] servo_angle,
	output logic                         moved,
	output logic                         last
);
	import jsi_pkg::*;

	localparam int AB = ANGLE_BITS;
	localparam int NJ = LEGS * JOINTS;
	localparam int IW = $clog2(NJ);
	localparam int LW = (LEGS > 1) ? $clog2(LEGS) : 1;
	localparam int SW = (AB > LIM_W) ? AB : LIM_W;
	localparam int CW = SW + 2;
	localparam int XW = ((AB > VAL_W) ? AB : VAL_W) + 2;
	localparam int NW = AB + TP_W;
	localparam int NCW = $clog2(NW);
	localparam logic signed [XW-1:0] ANG_HI = XW'((64'sd1 <<< (AB - 1)) - 64'sd1);
	localparam logic signed [XW-1:0] ANG_LO = -ANG_HI - XW'(1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SETC  = 4'd1;
	localparam logic [3:0] S_TGT   = 4'd2;
	localparam logic [3:0] S_DIFF  = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_DIV   = 4'd5;
	localparam logic [3:0] S_STEP  = 4'd6;
	localparam logic [3:0] S_TICKA = 4'd7;
	localparam logic [3:0] S_TICKB = 4'd8;

	function automatic logic [AB-1:0] clamp_ang(input logic signed [XW-1:0] x,
	                                            input logic [LIM_W-1:0] lim);
		logic signed [XW-1:0] l;
		logic signed [XW-1:0] y;
		l = {{(XW-LIM_W){1'b0}}, lim};
		if (x < -l)
			y = -l;
		else if (x > l)
			y = l;
		else
			y = x;
		if (y < ANG_LO)
			y = ANG_LO;
		else if (y > ANG_HI)
			y = ANG_HI;
		return y[AB-1:0];
	endfunction

	logic [LIM_W-1:0] max_angle_q;
	logic [LIM_W-1:0] min_step_q;
	logic [TP_W-1:0]  tick_period_q;

	logic [AB-1:0] cur_q  [NJ];
	logic [AB-1:0] tgt_q  [NJ];
	logic [SW-1:0] step_q [NJ];

	logic [3:0]         state_q;
	logic [OP_W-1:0]    op_q;
	logic [LW-1:0]      leg_q;
	logic [JOINT_W-1:0] joint_q;
	logic signed [VAL_W-1:0] cv_q;
	logic signed [VAL_W-1:0] tv_q;
	logic [MT_W-1:0]    mt_q;
	logic [AB-1:0]      d_q;
	logic [NW-1:0]      num_q;
	logic [MT_W-1:0]    rem_q;
	logic [NCW-1:0]     cnt_q;
	logic [AB:0]        e_q;

	logic               out_valid_q;
	logic [LEG_W-1:0]   out_leg_q;
	logic [JOINT_W-1:0] out_joint_q;
	logic [AB-1:0]      out_ang_q;
	logic               moved_q;
	logic               last_q;

	logic [IW-1:0]      idx;
	logic [AB-1:0]      cur_r;
	logic [AB-1:0]      tgt_r;
	logic [SW-1:0]      step_r;
	logic               out_free;
	logic               rel;
	logic signed [VAL_W-1:0] v_sel;
	logic signed [XW-1:0] base_x;
	logic [AB-1:0]      set_val;
	logic [AB:0]        diff;
	logic [AB:0]        diff_abs;
	logic [NW-1:0]      prod;
	logic [MT_W+1:0]    trial;
	logic [NW-1:0]      d_ext;
	logic [NW-1:0]      ms_ext;
	logic [SW-1:0]      step_new;
	logic signed [CW-1:0] e_x;
	logic signed [CW-1:0] st_x;
	logic signed [CW-1:0] ms_x;
	logic signed [CW-1:0] cur_x;
	logic signed [CW-1:0] tick_x;
	logic [AB-1:0]      tick_ang;
	logic               tick_mv;
	logic               tick_last;
	logic               leg_ok;
	logic [AB+VAL_W-1:0] ang_ext;

	assign idx = IW'(32'(leg_q) * JOINTS + 32'(joint_q));
	assign cur_r = cur_q[idx];
	assign tgt_r = tgt_q[idx];
	assign step_r = step_q[idx];
	assign out_free = !out_valid_q || out_ready;
	assign leg_ok = ({2'b00, leg_index} < 5'(LEGS));

	// shared clamp path for set current / set target
	always_comb begin
		rel = (op_q == OP_SET_CUR_REL) || (op_q == OP_SET_TGT_REL);
		v_sel = (joint_q == JOINT_COXA) ? cv_q : tv_q;
		base_x = (state_q == S_SETC) ? {{(XW-AB){cur_r[AB-1]}}, cur_r}
		                             : {{(XW-AB){tgt_r[AB-1]}}, tgt_r};
		if (rel)
			set_val = clamp_ang(base_x + {{(XW-VAL_W){v_sel[VAL_W-1]}}, v_sel},
			                    max_angle_q);
		else
			set_val = clamp_ang({{(XW-VAL_W){v_sel[VAL_W-1]}}, v_sel}, max_angle_q);
	end

	assign diff = {cur_r[AB-1], cur_r} - {tgt_r[AB-1], tgt_r};
	assign diff_abs = diff[AB] ? -diff : diff;
	assign prod = NW'(d_q) * NW'(tick_period_q);
	assign trial = {1'b0, rem_q, num_q[NW-1]} - {2'b00, mt_q};

	always_comb begin
		d_ext = NW'(d_q);
		ms_ext = NW'(min_step_q);
		if (num_q > d_ext)
			step_new = SW'(d_q);
		else if (num_q < ms_ext)
			step_new = SW'(min_step_q);
		else
			step_new = SW'(num_q);
	end

	always_comb begin
		e_x = {{(CW-AB-1){e_q[AB]}}, e_q};
		st_x = {2'b00, step_r};
		ms_x = {{(CW-LIM_W){1'b0}}, min_step_q};
		cur_x = {{(CW-AB){cur_r[AB-1]}}, cur_r};
		tick_mv = 1'b1;
		if (e_x > st_x)
			tick_x = cur_x - st_x;
		else if (e_x < -st_x)
			tick_x = cur_x + st_x;
		else if (e_x > ms_x)
			tick_x = cur_x - ms_x;
		else if (e_x < -ms_x)
			tick_x = cur_x + ms_x;
		else begin
			tick_x = {{(CW-AB){tgt_r[AB-1]}}, tgt_r};
			tick_mv = 1'b0;
		end
		tick_ang = tick_x[AB-1:0];
		tick_last = (32'(leg_q) == LEGS - 1) && (joint_q == JOINT_TIBIA);
	end

	// register port
	assign pready = 1'b1;
	always_comb begin
		case (paddr[3:2])
			REG_MAX_ANGLE:   prdata = {17'd0, max_angle_q};
			REG_MIN_STEP:    prdata = {17'd0, min_step_q};
			REG_TICK_PERIOD: prdata = {24'd0, tick_period_q};
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_angle_q <= MAX_ANGLE_RESET;
			min_step_q <= MIN_STEP_RESET;
			tick_period_q <= TICK_PERIOD_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_MAX_ANGLE:   max_angle_q <= pwdata[LIM_W-1:0];
				REG_MIN_STEP:    min_step_q <= pwdata[LIM_W-1:0];
				REG_TICK_PERIOD: tick_period_q <= pwdata[TP_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// sequencer, joint state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NJ; i++) begin
				cur_q[i] <= '0;
				tgt_q[i] <= '0;
				step_q[i] <= SW'(MIN_STEP_RESET);
			end
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= operation;
						leg_q <= LW'(leg_index);
						joint_q <= JOINT_COXA;
						cv_q <= coxa_value;
						tv_q <= tibia_value;
						mt_q <= (move_time == '0) ? MT_W'(1) : move_time;
						if (operation == OP_TICK) begin
							leg_q <= '0;
							state_q <= S_TICKA;
						end else if (leg_ok && ((operation == OP_SET_CUR_ABS) ||
						                        (operation == OP_SET_CUR_REL))) begin
							state_q <= S_SETC;
						end else if (leg_ok && ((operation == OP_SET_TGT_ABS) ||
						                        (operation == OP_SET_TGT_REL))) begin
							state_q <= S_TGT;
						end
					end
				end
				S_SETC: begin
					if (out_free) begin
						if (joint_q != JOINT_FEMUR)
							cur_q[idx] <= set_val;
						tgt_q[idx] <= (joint_q == JOINT_FEMUR) ? cur_r : set_val;
						out_valid_q <= 1'b1;
						out_leg_q <= LEG_W'(leg_q);
						out_joint_q <= joint_q;
						out_ang_q <= (joint_q == JOINT_FEMUR) ? cur_r : set_val;
						moved_q <= 1'b1;
						last_q <= (joint_q == JOINT_TIBIA);
						if (joint_q == JOINT_TIBIA)
							state_q <= S_IDLE;
						else
							joint_q <= joint_q + JOINT_W'(1);
					end
				end
				S_TGT: begin
					if (joint_q != JOINT_FEMUR)
						tgt_q[idx] <= set_val;
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					d_q <= diff_abs[AB-1:0];
					state_q <= S_MUL;
				end
				S_MUL: begin
					num_q <= prod;
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!trial[MT_W+1]) begin
						rem_q <= trial[MT_W-1:0];
						num_q <= {num_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[MT_W-2:0], num_q[NW-1]};
						num_q <= {num_q[NW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + NCW'(1);
					if (32'(cnt_q) == NW - 1)
						state_q <= S_STEP;
				end
				S_STEP: begin
					step_q[idx] <= step_new;
					if (joint_q == JOINT_TIBIA)
						state_q <= S_IDLE;
					else begin
						joint_q <= joint_q + JOINT_W'(1);
						state_q <= S_TGT;
					end
				end
				S_TICKA: begin
					e_q <= diff;
					state_q <= S_TICKB;
				end
				S_TICKB: begin
					if (out_free) begin
						cur_q[idx] <= tick_ang;
						out_valid_q <= 1'b1;
						out_leg_q <= LEG_W'(leg_q);
						out_joint_q <= joint_q;
						out_ang_q <= tick_ang;
						moved_q <= tick_mv;
						last_q <= tick_last;
						if (tick_last)
							state_q <= S_IDLE;
						else begin
							state_q <= S_TICKA;
							if (joint_q == JOINT_TIBIA) begin
								joint_q <= JOINT_COXA;
								leg_q <= leg_q + LW'(1);
							end else
								joint_q <= joint_q + JOINT_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ang_ext = {{VAL_W{out_ang_q[AB-1]}}, out_ang_q};
	assign out_valid = out_valid_q;
	assign out_leg = out_leg_q;
	assign out_joint = out_joint_q;
	assign servo_angle = ang_ext[VAL_W-1:0];
	assign moved = moved_q;
	assign last = last_q;

endmodule
